FILE: design/cdi_pkg.sv
// ---------------------------------------------------------------------------
// cdi_pkg: shared types and constants for the calendar date incrementer
// Payload structs for both channels, command and status codes, and the
// month length lookup used by the date arithmetic.
// ---------------------------------------------------------------------------
package cdi_pkg;

    localparam logic [1:0] CMD_ADD_DAY   = 2'd0;
    localparam logic [1:0] CMD_ADD_MONTH = 2'd1;
    localparam logic [1:0] CMD_ADD_YEAR  = 2'd2;
    localparam logic [1:0] CMD_RESERVED  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam logic signed [15:0] YEAR_MAX = 16'sh7FFF;
    localparam logic signed [15:0] YEAR_BAD = 16'sh8000;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    // Multiplicative inverse of 25 modulo 2**17. A value x below 2**17 is a
    // multiple of 25 exactly when (x * INV25) mod 2**17 <= DIV25_LIMIT.
    localparam int unsigned AbsWidth    = 17;
    localparam logic [16:0] INV25       = 17'h15C29;
    localparam logic [16:0] DIV25_LIMIT = 17'd5242;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [15:0] year_in;
        logic [3:0]         month_in;
        logic [4:0]         day_in;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] year_out;
        logic [3:0]         month_out;
        logic [4:0]         day_out;
        logic [1:0]         status;
    } out_item_t;

    // Length of a month; zero for a month code outside January..December.
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] n;
        begin
            unique case (m)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
                4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
                4'd2:                                       n = leap ? 5'd29 : 5'd28;
                default:                                    n = 5'd0;
            endcase
            return n;
        end
    endfunction

endpackage

FILE: design/calendar_date_increment.sv
// ---------------------------------------------------------------------------
// calendar_date_increment: Gregorian date plus one day, month or year
// Three-stage pipeline: year magnitude, divisibility products, date update.
// ---------------------------------------------------------------------------
// Usage:
// The input channel (s_valid, s_ready, s_payload) carries a command and a
// proleptic Gregorian date. The result channel (m_valid, m_ready, m_payload)
// returns exactly one date and status for every input transfer, in order.
// m_valid rises once an input transfer has passed through the stage 1 and
// stage 2 registers into the result register. One item is
// taken per cycle while the receiver keeps up; the three pipeline registers
// (absolute year, modular-inverse multiply for the divide-by-25 test, and
// the result register) each hold one item.
// Each stage loads when it is empty or when the stage after it moves, so
// bubbles close up and a stalled receiver fills the pipeline before
// s_ready falls. Nothing is dropped or repeated during a stall.
// Reset (aresetn low at a clock edge) empties every stage; there is no other
// state. Invalid dates and command 3 return status 1 with a zero date; an
// increment that would reach year 32768 returns status 2 with the input date.
// ---------------------------------------------------------------------------
module calendar_date_increment (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cdi_pkg::in_item_t   s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output cdi_pkg::out_item_t  m_payload
);

    logic adv1, adv2, adv3;
    logic v1_reg, v2_reg, v3_reg;

    // Stage 1 registers
    cdi_pkg::in_item_t s1_item_reg;
    logic [16:0]       s1_abs0_reg;
    logic [16:0]       s1_abs1_reg;
    logic [3:0]        s1_lo1_reg;

    // Stage 2 registers
    cdi_pkg::in_item_t s2_item_reg;
    logic [16:0]       s2_q0_reg;
    logic [16:0]       s2_q1_reg;
    logic [3:0]        s2_lo1_reg;

    // Stage 3 (output) register
    cdi_pkg::out_item_t out_reg;
    cdi_pkg::out_item_t out_next;

    assign adv3    = !v3_reg || m_ready;
    assign adv2    = !v2_reg || adv3;
    assign adv1    = !v1_reg || adv2;
    assign s_ready = adv1;
    assign m_valid = v3_reg;
    assign m_payload = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= s_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
    end

    // Stage 1: magnitudes of the year and of the following year.
    // Divisibility does not depend on sign.
    logic signed [16:0] y_ext;
    logic signed [16:0] y_plus1;
    logic [16:0]        abs0_next;
    logic [16:0]        abs1_next;

    always_comb begin
        y_ext     = {s_payload.year_in[15], s_payload.year_in};
        y_plus1   = y_ext + 17'sd1;
        abs0_next = y_ext[16] ? 17'(-y_ext) : 17'(y_ext);
        abs1_next = y_plus1[16] ? 17'(-y_plus1) : 17'(y_plus1);
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            s1_item_reg <= s_payload;
            s1_abs0_reg <= abs0_next;
            s1_abs1_reg <= abs1_next;
            s1_lo1_reg  <= y_plus1[3:0];
        end
    end

    // Stage 2: multiply by the inverse of 25; only the low 17 bits matter.
    logic [16:0] prod0, prod1;

    assign prod0 = s1_abs0_reg * cdi_pkg::INV25;
    assign prod1 = s1_abs1_reg * cdi_pkg::INV25;

    always_ff @(posedge aclk) begin
        if (adv2) begin
            s2_item_reg <= s1_item_reg;
            s2_q0_reg   <= prod0;
            s2_q1_reg   <= prod1;
            s2_lo1_reg  <= s1_lo1_reg;
        end
    end

    // Stage 3: leap flags and the date update.
    logic               div25_0, div25_1;
    logic               leap0, leap1;
    logic [1:0]         cmd;
    logic signed [15:0] y;
    logic [3:0]         m;
    logic [4:0]         d;
    logic [4:0]         len_in;
    logic [4:0]         len_new;
    logic               invalid;
    logic               year_inc;
    logic signed [15:0] ny;
    logic [3:0]         nm;
    logic [4:0]         nd;

    always_comb begin
        cmd = s2_item_reg.cmd;
        y   = s2_item_reg.year_in;
        m   = s2_item_reg.month_in;
        d   = s2_item_reg.day_in;

        div25_0 = (s2_q0_reg <= cdi_pkg::DIV25_LIMIT);
        div25_1 = (s2_q1_reg <= cdi_pkg::DIV25_LIMIT);
        leap0 = (y[1:0] == 2'd0 && !div25_0) || (y[3:0] == 4'd0 && div25_0);
        leap1 = (s2_lo1_reg[1:0] == 2'd0 && !div25_1) ||
                (s2_lo1_reg == 4'd0 && div25_1);

        len_in  = cdi_pkg::month_len(m, leap0);
        invalid = (cmd == cdi_pkg::CMD_RESERVED) || (y == cdi_pkg::YEAR_BAD) ||
                  (len_in == 5'd0) || (d == 5'd0) || (d > len_in);

        year_inc = 1'b0;
        nm       = m;
        nd       = d;
        unique case (cmd)
            cdi_pkg::CMD_ADD_DAY: begin
                if (d < len_in) begin
                    nd = d + 5'd1;
                end else if (m < cdi_pkg::MONTH_DEC) begin
                    nm = m + 4'd1;
                    nd = 5'd1;
                end else begin
                    year_inc = 1'b1;
                    nm       = cdi_pkg::MONTH_JAN;
                    nd       = 5'd1;
                end
            end
            cdi_pkg::CMD_ADD_MONTH: begin
                if (m < cdi_pkg::MONTH_DEC) begin
                    nm = m + 4'd1;
                end else begin
                    year_inc = 1'b1;
                    nm       = cdi_pkg::MONTH_JAN;
                end
            end
            default: begin
                year_inc = 1'b1;
            end
        endcase
        ny = year_inc ? y + 16'sd1 : y;

        // Clamp the day to the length of the resulting month.
        len_new = cdi_pkg::month_len(nm, year_inc ? leap1 : leap0);
        if (nd > len_new) nd = len_new;

        priority if (invalid) begin
            out_next.year_out  = '0;
            out_next.month_out = '0;
            out_next.day_out   = '0;
            out_next.status    = cdi_pkg::ST_INVALID;
        end else if (year_inc && y == cdi_pkg::YEAR_MAX) begin
            out_next.year_out  = y;
            out_next.month_out = m;
            out_next.day_out   = d;
            out_next.status    = cdi_pkg::ST_OVERFLOW;
        end else begin
            out_next.year_out  = ny;
            out_next.month_out = nm;
            out_next.day_out   = nd;
            out_next.status    = cdi_pkg::ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv3) out_reg <= out_next;
    end

    // An input stall can only come from a full pipeline behind a stalled receiver.
    a_stall_needs_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v1_reg && v2_reg && m_valid && !m_ready))
        else $error("input stalled while pipeline had room");

    a_ok_date_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.status == cdi_pkg::ST_OK) |->
        (m_payload.month_out >= cdi_pkg::MONTH_JAN &&
         m_payload.month_out <= cdi_pkg::MONTH_DEC && m_payload.day_out != 5'd0 &&
         m_payload.year_out != cdi_pkg::YEAR_BAD))
        else $error("ok result carries an illegal date");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.status == cdi_pkg::ST_INVALID) |->
        (m_payload.year_out == 16'sd0 && m_payload.month_out == 4'd0 &&
         m_payload.day_out == 5'd0))
        else $error("invalid result carries a nonzero date");

    a_overflow_top: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.status == cdi_pkg::ST_OVERFLOW) |->
        (m_payload.year_out == cdi_pkg::YEAR_MAX))
        else $error("overflow reported below the top year");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_payload.status != 2'd3))
        else $error("unused status code on the result channel");

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for calendar_date_increment
// Drives dates and commands through the input channel with random gaps,
// stalls the result channel at random, predicts every result from an
// independent model of the Gregorian calendar and compares field by field.
// ---------------------------------------------------------------------------
module testbench;

    localparam int RANDOM_ITEMS = 1025;
    localparam int SETTLE_CYCLES = 8;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    cdi_pkg::in_item_t  s_payload = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    cdi_pkg::out_item_t m_payload;

    cdi_pkg::out_item_t expected_dates[$];
    int          error_count = 0;
    int          n_dates_sent = 0;
    int          n_results = 0;
    int          n_by_status[4] = '{0, 0, 0, 0};
    int          n_by_cmd[4] = '{0, 0, 0, 0};
    int unsigned src_gap = 0;
    int unsigned rx_hold = 4;
    bit          tx_no_idle = 1'b0;
    bit          rx_no_idle = 1'b0;

    calendar_date_increment dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Leap rule holds for year zero and negative years, so % must truncate.
    function automatic bit is_leap_year(input int y);
        if ((y % 400) == 0) return 1'b1;
        if ((y % 100) == 0) return 1'b0;
        return (y % 4) == 0;
    endfunction

    function automatic int last_day(input int y, input logic [3:0] m);
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 31;
            4'd4, 4'd6, 4'd9, 4'd11:                    return 30;
            cdi_pkg::MONTH_FEB:                         return is_leap_year(y) ? 29 : 28;
            default:                                    return 0;
        endcase
    endfunction

    function automatic cdi_pkg::out_item_t predict_next_date(input cdi_pkg::in_item_t req);
        cdi_pkg::out_item_t res;
        int        y;
        int        ny;
        int        nm;
        int        nd;
        int        len;
        y   = $signed(req.year_in);
        len = last_day(y, req.month_in);
        res = '0;
        if (req.cmd == cdi_pkg::CMD_RESERVED || req.year_in == cdi_pkg::YEAR_BAD ||
            len == 0 || req.day_in == 5'd0 || int'(req.day_in) > len) begin
            res.status = cdi_pkg::ST_INVALID;
            return res;
        end
        ny = y;
        nm = req.month_in;
        nd = req.day_in;
        case (req.cmd)
            cdi_pkg::CMD_ADD_DAY: begin
                if (nd < len) begin
                    nd = nd + 1;
                end else if (nm < 12) begin
                    nm = nm + 1;
                    nd = 1;
                end else begin
                    ny = y + 1;
                    nm = 1;
                    nd = 1;
                end
            end
            cdi_pkg::CMD_ADD_MONTH: begin
                if (nm < 12) begin
                    nm = nm + 1;
                end else begin
                    ny = y + 1;
                    nm = 1;
                end
            end
            default: ny = y + 1;
        endcase
        if (ny > int'(cdi_pkg::YEAR_MAX)) begin
            res.year_out  = req.year_in;
            res.month_out = req.month_in;
            res.day_out   = req.day_in;
            res.status    = cdi_pkg::ST_OVERFLOW;
        end else begin
            if (nd > last_day(ny, nm[3:0])) nd = last_day(ny, nm[3:0]);
            res.year_out  = ny[15:0];
            res.month_out = nm[3:0];
            res.day_out   = nd[4:0];
            res.status    = cdi_pkg::ST_OK;
        end
        return res;
    endfunction

    // Valid is only lowered when the next item is not ready at once, so a
    // back-to-back transfer never sees valid dropped and raised in one step.
    task automatic send_date(input logic [1:0] cmd, input int year, input int month,
                             input int day);
        cdi_pkg::in_item_t item;
        item.cmd      = cmd;
        item.year_in  = year[15:0];
        item.month_in = month[3:0];
        item.day_in   = day[4:0];
        if (src_gap != 0) repeat (src_gap) @(posedge aclk);
        s_valid   <= 1'b1;
        s_payload <= item;
        do @(posedge aclk); while (!s_ready);
        expected_dates.push_back(predict_next_date(item));
        n_dates_sent++;
        n_by_cmd[cmd]++;
        if ($urandom_range(0, 39) == 0) tx_no_idle = !tx_no_idle;
        src_gap = tx_no_idle ? 0 : $urandom_range(0, 14);
        if (src_gap != 0) s_valid <= 1'b0;
    endtask

    task automatic wait_all_results();
        if (src_gap == 0) s_valid <= 1'b0;
        src_gap = 0;
        @(posedge aclk);
        while (expected_dates.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic check_result(input cdi_pkg::out_item_t got);
        cdi_pkg::out_item_t want;
        if (expected_dates.size() == 0) begin
            $error("result transfer with no outstanding date: year %0d month %0d day %0d",
                   got.year_out, got.month_out, got.day_out);
            error_count++;
            return;
        end
        want = expected_dates.pop_front();
        n_results++;
        n_by_status[want.status]++;
        if (got.year_out !== want.year_out) begin
            $error("year_out mismatch: expected %0d, actual %0d", want.year_out, got.year_out);
            error_count++;
        end
        if (got.month_out !== want.month_out) begin
            $error("month_out mismatch: expected %0d, actual %0d",
                   want.month_out, got.month_out);
            error_count++;
        end
        if (got.day_out !== want.day_out) begin
            $error("day_out mismatch: expected %0d, actual %0d", want.day_out, got.day_out);
            error_count++;
        end
        if (got.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
            error_count++;
        end
    endtask

    // Result side: check every transfer, then hold ready low for a random
    // number of cycles before taking the next one.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) check_result(m_payload);
        if (rx_hold != 0) begin
            rx_hold = rx_hold - 1;
            if (rx_hold == 0) m_ready <= 1'b1;
        end else if (m_valid && m_ready) begin
            if ($urandom_range(0, 39) == 0) rx_no_idle = !rx_no_idle;
            rx_hold = rx_no_idle ? 0 : $urandom_range(0, 14);
            if (rx_hold != 0) m_ready <= 1'b0;
        end
    end

    task automatic test_rollover();
        send_date(cdi_pkg::CMD_ADD_DAY, 2023, 1, 31);
        send_date(cdi_pkg::CMD_ADD_DAY, 2023, 12, 31);
        send_date(cdi_pkg::CMD_ADD_DAY, 2024, 2, 28);
        send_date(cdi_pkg::CMD_ADD_DAY, 1900, 2, 28);
        send_date(cdi_pkg::CMD_ADD_DAY, 2000, 2, 29);
        send_date(cdi_pkg::CMD_ADD_DAY, -1, 12, 31);
        send_date(cdi_pkg::CMD_ADD_DAY, 0, 2, 28);
        send_date(cdi_pkg::CMD_ADD_DAY, -100, 2, 28);
        send_date(cdi_pkg::CMD_ADD_DAY, -400, 2, 28);
        send_date(cdi_pkg::CMD_ADD_MONTH, 2023, 12, 15);
    endtask

    task automatic test_clamping();
        send_date(cdi_pkg::CMD_ADD_MONTH, 2023, 1, 31);
        send_date(cdi_pkg::CMD_ADD_MONTH, 2024, 1, 31);
        send_date(cdi_pkg::CMD_ADD_MONTH, 2024, 3, 31);
        send_date(cdi_pkg::CMD_ADD_YEAR, 2024, 2, 29);
    endtask

    task automatic test_year_limits();
        send_date(cdi_pkg::CMD_ADD_YEAR, 32767, 6, 1);
        send_date(cdi_pkg::CMD_ADD_DAY, 32767, 12, 31);
        send_date(cdi_pkg::CMD_ADD_MONTH, 32767, 12, 1);
        send_date(cdi_pkg::CMD_ADD_DAY, 32767, 12, 30);
        send_date(cdi_pkg::CMD_ADD_YEAR, -32767, 1, 1);
    endtask

    task automatic test_invalid_inputs();
        send_date(cdi_pkg::CMD_ADD_DAY, -32768, 1, 1);
        send_date(cdi_pkg::CMD_ADD_DAY, 2020, 0, 10);
        send_date(cdi_pkg::CMD_ADD_MONTH, 2020, 15, 10);
        send_date(cdi_pkg::CMD_ADD_DAY, 2020, 5, 0);
        send_date(cdi_pkg::CMD_ADD_DAY, 2021, 4, 31);
        send_date(cdi_pkg::CMD_ADD_YEAR, 2023, 2, 29);
        send_date(cdi_pkg::CMD_RESERVED, 2020, 6, 15);
    endtask

    function automatic int pick_year();
        case ($urandom_range(0, 4))
            0:       return 32767 - int'($urandom_range(0, 8));
            1:       return -32767 + int'($urandom_range(0, 8));
            2:       return int'($urandom_range(0, 3000)) - 500;
            3:       return (int'($urandom_range(0, 654)) - 327) * 100;
            default: return int'($urandom_range(0, 65534)) - 32767;
        endcase
    endfunction

    // Mostly well-formed dates, often on the last day of a month, plus raw
    // noise that covers every bit pattern of the input fields.
    task automatic test_random_dates(input int count);
        int y;
        int m;
        int d;
        int len;
        repeat (count) begin
            if ($urandom_range(0, 9) == 0) begin
                send_date(2'($urandom_range(0, 3)), int'($urandom_range(0, 65535)),
                          $urandom_range(0, 15), $urandom_range(0, 31));
            end else begin
                y   = pick_year();
                m   = $urandom_range(1, 12);
                len = last_day(y, m[3:0]);
                d   = ($urandom_range(0, 9) < 4) ? len : int'($urandom_range(1, len));
                send_date(2'($urandom_range(0, 2)), y, m, d);
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_rollover();
        test_clamping();
        test_year_limits();
        test_invalid_inputs();
        test_random_dates(RANDOM_ITEMS / 2);
        // Let the pipeline empty completely before the rest of the run.
        wait_all_results();
        test_random_dates(RANDOM_ITEMS - RANDOM_ITEMS / 2);
        wait_all_results();
        if (expected_dates.size() != 0) begin
            $error("%0d expected results never arrived", expected_dates.size());
            error_count++;
        end
        $display("Sent %0d dates: %0d add day, %0d add month, %0d add year, %0d reserved.",
                 n_dates_sent, n_by_cmd[0], n_by_cmd[1], n_by_cmd[2], n_by_cmd[3]);
        $display("Checked %0d results: %0d ok, %0d invalid date, %0d year overflow.",
                 n_results, n_by_status[0], n_by_status[1], n_by_status[2]);
        if (error_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Run timed out with %0d results outstanding.", expected_dates.size());
        $display("testbench: FAIL");
        $finish;
    end

endmodule

FILE: calendar_date_increment.f
design/cdi_pkg.sv
design/calendar_date_increment.sv
dv/testbench.sv
